// ===== rtl/gtq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gtq_pkg: shared types and constants of the grouped team queue
// Sizes of the id space, group count and per-group ring depth, the action and
// status codes, and the command and view records of the bookkeeping block.
// ----------------------------------------------------------------------------
package gtq_pkg;

  localparam int MAX_ITEM_ID = 16383;
  localparam int NUM_GROUPS  = 16;
  localparam int GROUP_DEPTH = 1024;

  localparam int MAP_DEPTH   = MAX_ITEM_ID + 1;
  localparam int STORE_DEPTH = NUM_GROUPS * GROUP_DEPTH;

  localparam int ID_W     = $clog2(MAP_DEPTH);
  localparam int GRP_W    = $clog2(NUM_GROUPS);
  localparam int HEAD_W   = $clog2(GROUP_DEPTH);
  localparam int CNT_W    = $clog2(GROUP_DEPTH + 1);
  localparam int OCNT_W   = $clog2(NUM_GROUPS + 1);
  localparam int STORE_AW = $clog2(STORE_DEPTH);
  localparam int ACT_W    = 2;
  localparam int STAT_W   = 2;

  // action codes
  localparam logic [ACT_W-1:0] ACT_ASSIGN  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ENQUEUE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_DEQUEUE = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  // update request to the bookkeeping block; grp also selects the view
  typedef struct packed {
    logic             push;
    logic             pop;
    logic [GRP_W-1:0] grp;
  } book_cmd_t;

  // ring state of the selected group and the group-order queue
  typedef struct packed {
    logic [HEAD_W-1:0] head;
    logic [CNT_W-1:0]  count;
    logic [HEAD_W-1:0] slot;
    logic [GRP_W-1:0]  front;
    logic [OCNT_W-1:0] order_count;
  } book_view_t;

  // id store address of a slot in a group's ring
  function automatic logic [STORE_AW-1:0] store_addr(input logic [GRP_W-1:0]  grp,
                                                     input logic [HEAD_W-1:0] slot);
    logic [STORE_AW-1:0] base;
    base = STORE_AW'(grp) * STORE_AW'(GROUP_DEPTH);
    return base + STORE_AW'(slot);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/gtq_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gtq_in_if: input channel of the grouped team queue
// Valid/ready channel that carries one action with its item id and group.
// ----------------------------------------------------------------------------
interface gtq_in_if;
  import gtq_pkg::*;

  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] action;
  logic [ID_W-1:0]  item_id;
  logic [GRP_W-1:0] group_id;

  modport source (output valid, output action, output item_id, output group_id,
                  input ready);
  modport sink (input valid, input action, input item_id, input group_id,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/gtq_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gtq_out_if: result channel of the grouped team queue
// Valid/ready channel that carries the status and any dequeued id and group.
// ----------------------------------------------------------------------------
interface gtq_out_if;
  import gtq_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [ID_W-1:0]   dequeued_id;
  logic [GRP_W-1:0]  dequeued_group;

  modport source (output valid, output status, output dequeued_id,
                  output dequeued_group, input ready);
  modport sink (input valid, input status, input dequeued_id,
                input dequeued_group, output ready);
endinterface
`default_nettype wire

// ===== rtl/gtq_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gtq_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered and holds until
// the next read.
// ----------------------------------------------------------------------------
module gtq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/gtq_book.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gtq_book: ring pointers of the groups and the group-order queue
// Holds head and count of every group ring and the queue of groups that have
// ids waiting; applies push and pop updates and shows the selected group.
// ----------------------------------------------------------------------------
module gtq_book (
  input  logic               clk,
  input  logic               rst,
  input  gtq_pkg::book_cmd_t cmd,
  output gtq_pkg::book_view_t view
);
  import gtq_pkg::*;

  logic [HEAD_W-1:0] head [NUM_GROUPS];
  logic [CNT_W-1:0]  count [NUM_GROUPS];
  logic [GRP_W-1:0]  order_store [NUM_GROUPS];
  logic [GRP_W-1:0]  order_head;
  logic [OCNT_W-1:0] order_count;

  logic [HEAD_W:0]   slot_sum;
  logic [HEAD_W-1:0] slot;
  logic [OCNT_W:0]   tail_sum;
  logic [GRP_W-1:0]  tail;
  logic [HEAD_W-1:0] head_inc;
  logic [GRP_W-1:0]  order_head_inc;
  logic              join_order;
  logic              retire;

  // slot after the last id of the selected group, wrapped into the ring
  assign slot_sum = (HEAD_W+1)'(head[cmd.grp]) + (HEAD_W+1)'(count[cmd.grp]);
  always_comb begin
    if (slot_sum >= (HEAD_W+1)'(GROUP_DEPTH)) begin
      slot = HEAD_W'(slot_sum - (HEAD_W+1)'(GROUP_DEPTH));
    end else begin
      slot = HEAD_W'(slot_sum);
    end
  end

  // tail slot of the group-order queue
  assign tail_sum = (OCNT_W+1)'(order_head) + (OCNT_W+1)'(order_count);
  always_comb begin
    if (tail_sum >= (OCNT_W+1)'(NUM_GROUPS)) begin
      tail = GRP_W'(tail_sum - (OCNT_W+1)'(NUM_GROUPS));
    end else begin
      tail = GRP_W'(tail_sum);
    end
  end

  assign head_inc = (head[cmd.grp] == HEAD_W'(GROUP_DEPTH - 1)) ? '0
                                                                : head[cmd.grp] + 1'b1;
  assign order_head_inc = (order_head == GRP_W'(NUM_GROUPS - 1)) ? '0
                                                                 : order_head + 1'b1;

  assign join_order = cmd.push && (count[cmd.grp] == '0) &&
                      (order_count < OCNT_W'(NUM_GROUPS));
  assign retire     = cmd.pop && (count[cmd.grp] <= CNT_W'(1));

  // view fields in order: head, count, slot, front, order_count
  assign view = {head[cmd.grp], count[cmd.grp], slot, order_store[order_head],
                 order_count};

  // advance ring pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
        head[g]  <= '0;
        count[g] <= '0;
      end
    end else if (cmd.push) begin
      count[cmd.grp] <= count[cmd.grp] + 1'b1;
    end else if (cmd.pop && (count[cmd.grp] != '0)) begin
      head[cmd.grp]  <= head_inc;
      count[cmd.grp] <= count[cmd.grp] - 1'b1;
    end
  end

  // join a group at the back of the order queue
  always_ff @(posedge clk) begin
    if (join_order) begin
      order_store[tail] <= cmd.grp;
    end
  end

  // track front and fill of the order queue
  always_ff @(posedge clk) begin
    if (rst) begin
      order_head  <= '0;
      order_count <= '0;
    end else if (join_order) begin
      order_count <= order_count + 1'b1;
    end else if (retire) begin
      order_head  <= order_head_inc;
      order_count <= order_count - 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_order_bound: assert property (@(posedge clk) disable iff (rst)
    order_count <= OCNT_W'(NUM_GROUPS))
    else $error("order queue fill beyond group count");
  a_push_pop_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.push && cmd.pop))
    else $error("push and pop requested together");
  a_join_grows: assert property (@(posedge clk) disable iff (rst)
    join_order |=> order_count == $past(order_count) + 1'b1)
    else $error("order queue did not grow on join");
`endif

endmodule
`default_nettype wire

// ===== rtl/grouped_team_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// grouped_team_queue: team queue of item ids split into groups
// Group map, per-group id rings and group-order queue with a result register.
// ----------------------------------------------------------------------------
// After reset the block sweeps all MAP_DEPTH entries of the group map to
// zero, one entry per cycle; in_item.ready stays low meanwhile. For each
// item, the accept cycle issues the read of the group map and, on dequeue,
// of the id store; in the busy state, once the result register is free, the
// block writes the map (assign) or the id store (enqueue), updates the ring
// pointers (enqueue, dequeue) and loads the result register. The block takes
// a new item while a result waits in that register; the new item holds in
// the busy state until the register is free. One result comes out per item.
module grouped_team_queue (
  input logic        clk,
  input logic        rst,
  gtq_in_if.sink     in_item,
  gtq_out_if.source  result
);
  import gtq_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_BUSY  = 3'b100
  } state_t;

  state_t state, state_next;

  logic [ID_W-1:0]  clr_addr;
  logic [ACT_W-1:0] act;
  logic [ID_W-1:0]  item;
  logic [GRP_W-1:0] grp;

  logic accept, out_free, commit, full;

  logic              map_we, map_re;
  logic [ID_W-1:0]   map_waddr;
  logic [GRP_W-1:0]  map_wdata, map_rdata;

  logic                fifo_we, fifo_re;
  logic [STORE_AW-1:0] fifo_waddr, fifo_raddr;
  logic [ID_W-1:0]     fifo_rdata;

  book_cmd_t  cmd;
  book_view_t view;
  logic             book_push, book_pop;
  logic [GRP_W-1:0] work_grp;

  logic              out_valid;
  logic [STAT_W-1:0] status, status_next;
  logic [ID_W-1:0]   dq_id, dq_id_next;
  logic [GRP_W-1:0]  dq_grp, dq_grp_next;

  assign in_item.ready = (state == ST_IDLE);
  assign accept        = in_item.valid && in_item.ready;
  assign out_free      = !out_valid || result.ready;
  assign commit        = (state == ST_BUSY) && out_free;
  assign full          = view.count >= CNT_W'(GROUP_DEPTH);

  // sequence clear, accept and commit
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_addr == ID_W'(MAP_DEPTH - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (accept) state_next = ST_BUSY;
      ST_BUSY:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  // hold the accepted item
  always_ff @(posedge clk) begin
    if (accept) begin
      act  <= in_item.action;
      item <= in_item.item_id;
      grp  <= in_item.group_id;
    end
  end

  // reads issued on accept
  assign map_re     = accept;
  assign fifo_re    = accept && (in_item.action == ACT_DEQUEUE);
  assign fifo_raddr = store_addr(view.front, view.head);
  assign fifo_waddr = store_addr(work_grp, view.slot);

  // select the group under work: the map result on enqueue, else the front
  always_comb begin
    work_grp = view.front;
    if ((state == ST_BUSY) && (act == ACT_ENQUEUE)) begin
      work_grp = map_rdata;
    end
  end

  assign cmd = {book_push, book_pop, work_grp};

  // write back and build the result
  always_comb begin
    book_push   = 1'b0;
    book_pop    = 1'b0;
    fifo_we     = 1'b0;
    map_we      = 1'b0;
    map_waddr   = item;
    map_wdata   = grp;
    status_next = STAT_OK;
    dq_id_next  = '0;
    dq_grp_next = '0;
    if (state == ST_CLEAR) begin
      map_we    = 1'b1;
      map_waddr = clr_addr;
      map_wdata = '0;
    end else if (commit) begin
      case (act)
        ACT_ASSIGN: begin
          map_we = (GRP_W+1)'(grp) < (GRP_W+1)'(NUM_GROUPS);
        end
        ACT_ENQUEUE: begin
          if (full) begin
            status_next = STAT_FULL;
          end else begin
            fifo_we   = 1'b1;
            book_push = 1'b1;
          end
        end
        ACT_DEQUEUE: begin
          if (view.order_count == '0) begin
            status_next = STAT_EMPTY;
          end else if (view.count == '0) begin
            status_next = STAT_EMPTY;
            book_pop    = 1'b1;
          end else begin
            dq_id_next  = fifo_rdata;
            dq_grp_next = work_grp;
            book_pop    = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      status <= status_next;
      dq_id  <= dq_id_next;
      dq_grp <= dq_grp_next;
    end
  end

  assign result.valid          = out_valid;
  assign result.status         = status;
  assign result.dequeued_id    = dq_id;
  assign result.dequeued_group = dq_grp;

  gtq_ram #(
    .WIDTH (GRP_W),
    .DEPTH (MAP_DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .re    (map_re),
    .raddr (in_item.item_id),
    .rdata (map_rdata)
  );

  gtq_ram #(
    .WIDTH (ID_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (fifo_we),
    .waddr (fifo_waddr),
    .wdata (item),
    .re    (fifo_re),
    .raddr (fifo_raddr),
    .rdata (fifo_rdata)
  );

  gtq_book u_book (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .view (view)
  );

`ifndef SYNTHESIS
  a_store_rw_excl: assert property (@(posedge clk) disable iff (rst)
    !(fifo_we && fifo_re))
    else $error("id store read and write in one cycle");
  a_map_rw_excl: assert property (@(posedge clk) disable iff (rst)
    !(map_we && map_re))
    else $error("group map read and write in one cycle");
  a_commit_result: assert property (@(posedge clk) disable iff (rst)
    commit |=> out_valid)
    else $error("committed item left no result");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> view.order_count != '0)
    else $error("pop with empty order queue");
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !in_item.ready)
    else $error("input ready during map clear");
`endif

endmodule
`default_nettype wire
